[hw/rtl/lfte_pkg.sv]
// ----------------------------------------------------------------------------
// lfte_pkg
// Shared constants and types for the line folder with tab expansion.
// ----------------------------------------------------------------------------
package lfte_pkg;

    // Default line length in characters.
    localparam int LINE_WIDTH_DEF = 32;

    // Width of the column count and of every index into the line.
    localparam int COL_W = 6;

    // Width of one character byte and of the tab step register.
    localparam int CHAR_W = 8;
    localparam int STEP_W = 6;

    // Reset value of the tab step register.
    localparam logic [STEP_W-1:0] TAB_STEP_RST = 6'd8;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

    // Control that is common to every cell of the line.
    typedef struct packed {
        logic              shift;
        logic [CHAR_W-1:0] wr_data;
    } cell_ctrl_t;

endpackage

[hw/rtl/lfte_if.sv]
// ----------------------------------------------------------------------------
// lfte_in_if / lfte_out_if
// Valid/ready channels for input characters and for emitted characters.
// ----------------------------------------------------------------------------
interface lfte_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

interface lfte_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       last_of_run;

    modport source (output valid, output char_out, output last_of_run, input ready);
    modport sink (input valid, input char_out, input last_of_run, output ready);
endinterface

[hw/rtl/lfte_cell.sv]
// ----------------------------------------------------------------------------
// lfte_cell
// One character position of the line. It loads a new character when its
// position is written and takes its right neighbor's character on a shift.
// ----------------------------------------------------------------------------
module lfte_cell
    import lfte_pkg::*;
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic              wr_en,
    input  logic [CHAR_W-1:0] nbr_data,
    output logic [CHAR_W-1:0] data
);

    logic [CHAR_W-1:0] data_reg;

    // A write and a shift never coincide; the write takes priority.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            data_reg <= ctrl.wr_data;
        end
        else if (ctrl.shift)
        begin
            data_reg <= nbr_data;
        end
    end

    assign data = data_reg;

endmodule

[hw/rtl/line_folder_with_tab_expansion.sv]
// ----------------------------------------------------------------------------
// line_folder_with_tab_expansion
// Folds a character stream into lines of at most LINE_WIDTH characters.
// ----------------------------------------------------------------------------
// The line is held in a row of LINE_WIDTH character cells. A plain character
// is written into the cell at the current column. When the line fills, the
// block folds just after the last blank at column one or higher (tracked as
// characters arrive, so no search is needed) or at full width, and shifts
// the folded part out of cell 0 one character a cycle while the output is
// ready, followed by a newline; the rest of the line ends up at the front. A
// newline flushes the line the same way when it is not empty. A tab first
// reduces the column modulo the tab step by repeated subtraction to find its
// phase between stops, then writes one space a cycle, and a full line is
// emitted if the spaces reach the end. A tab_step of zero acts as one.
// Configuration is to be written only while no item is in progress; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module line_folder_with_tab_expansion
    import lfte_pkg::*;
#(
    parameter int LINE_WIDTH = LINE_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [STEP_W-1:0] cfg_wr_data,
    lfte_in_if.sink           in_ch,
    lfte_out_if.source        out_ch
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_TABMOD = 2'd1;
    localparam logic [1:0] S_TAB    = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    localparam logic [COL_W-1:0] WIDTH_C = COL_W'(LINE_WIDTH);

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] tab_step_reg;
    logic [COL_W-1:0]  column_reg, column_next;
    logic [COL_W-1:0]  rem_reg, rem_next;
    logic [COL_W-1:0]  count_reg, count_next;
    logic              sp_valid_reg, sp_valid_next;
    logic [COL_W-1:0]  sp_idx_reg, sp_idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg;
    logic              out_last_reg;

    logic [STEP_W-1:0] step_eff;
    logic              in_acc;
    logic              out_load;
    logic              cell_wr;
    logic              is_space;
    logic              hit_valid;
    logic [COL_W-1:0]  hit_idx;
    logic [COL_W-1:0]  fold;
    logic [COL_W-1:0]  col_inc;
    logic [COL_W-1:0]  rem_inc;
    cell_ctrl_t        cell_ctrl;
    logic [CHAR_W-1:0] cell_data [LINE_WIDTH];

    assign step_eff = (tab_step_reg == '0) ? STEP_W'(1) : tab_step_reg;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_acc = in_ch.valid && in_ch.ready;
    assign out_load = (state_reg == S_EMIT) && (!out_valid_reg || out_ch.ready);

    // A character cell is written for plain characters and for tab spaces.
    assign cell_wr = (in_acc && in_ch.char_in != CH_TAB && in_ch.char_in != CH_NL)
                     || (state_reg == S_TAB);
    assign cell_ctrl.wr_data = (state_reg == S_TAB) ? CH_SPACE : in_ch.char_in;
    assign cell_ctrl.shift = out_load && (count_reg != '0);

    // Fold point: just after the last blank at column one or higher.
    assign is_space = (in_ch.char_in == CH_SPACE) && (column_reg != '0);
    assign hit_valid = is_space || sp_valid_reg;
    assign hit_idx = is_space ? column_reg : sp_idx_reg;
    assign fold = hit_valid ? hit_idx + COL_W'(1) : WIDTH_C;
    assign col_inc = column_reg + COL_W'(1);
    assign rem_inc = (rem_reg + COL_W'(1) == COL_W'(step_eff)) ? '0 : rem_reg + COL_W'(1);

    // Row of character cells; each shifts toward cell 0 during emission.
    for (genvar i = 0; i < LINE_WIDTH; i++)
    begin : g_cell
        logic [CHAR_W-1:0] nbr;
        if (i == LINE_WIDTH - 1)
        begin : g_end
            assign nbr = CH_SPACE;
        end
        else
        begin : g_mid
            assign nbr = cell_data[i+1];
        end
        lfte_cell u_cell (
            .clk      (clk),
            .ctrl     (cell_ctrl),
            .wr_en    (cell_wr && column_reg == COL_W'(i)),
            .nbr_data (nbr),
            .data     (cell_data[i])
        );
    end

    // Sequencer for characters, tabs and line emission.
    always_comb
    begin
        state_next    = state_reg;
        column_next   = column_reg;
        rem_next      = rem_reg;
        count_next    = count_reg;
        sp_valid_next = sp_valid_reg;
        sp_idx_next   = sp_idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_ch.char_in == CH_TAB)
                    begin
                        rem_next   = column_reg;
                        state_next = S_TABMOD;
                    end
                    else if (in_ch.char_in == CH_NL)
                    begin
                        count_next    = column_reg;
                        column_next   = '0;
                        sp_valid_next = 1'b0;
                        if (column_reg != '0)
                        begin
                            state_next = S_EMIT;
                        end
                    end
                    else if (col_inc == WIDTH_C)
                    begin
                        count_next    = fold;
                        column_next   = WIDTH_C - fold;
                        sp_valid_next = 1'b0;
                        state_next    = S_EMIT;
                    end
                    else
                    begin
                        column_next = col_inc;
                        if (is_space)
                        begin
                            sp_valid_next = 1'b1;
                            sp_idx_next   = column_reg;
                        end
                    end
                end
            end
            S_TABMOD:
            begin
                // Reduce the column modulo the tab step, one subtraction a cycle.
                if (rem_reg >= COL_W'(step_eff))
                begin
                    rem_next = rem_reg - COL_W'(step_eff);
                end
                else
                begin
                    state_next = S_TAB;
                end
            end
            S_TAB:
            begin
                if (column_reg != '0)
                begin
                    sp_valid_next = 1'b1;
                    sp_idx_next   = column_reg;
                end
                rem_next = rem_inc;
                if (col_inc == WIDTH_C)
                begin
                    count_next    = WIDTH_C;
                    column_next   = '0;
                    sp_valid_next = 1'b0;
                    state_next    = S_EMIT;
                end
                else
                begin
                    column_next = col_inc;
                    if (rem_inc == '0)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - COL_W'(1);
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register valid.
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tab_step_reg  <= TAB_STEP_RST;
            column_reg    <= '0;
            rem_reg       <= '0;
            count_reg     <= '0;
            sp_valid_reg  <= 1'b0;
            sp_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            column_reg    <= column_next;
            rem_reg       <= rem_next;
            count_reg     <= count_next;
            sp_valid_reg  <= sp_valid_next;
            sp_idx_reg    <= sp_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                tab_step_reg <= cfg_wr_data;
            end
        end
    end

    // Output payload: a stored character, or the closing newline.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_char_reg <= (count_reg != '0) ? cell_data[0] : CH_NL;
            out_last_reg <= (count_reg == '0);
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.char_out    = out_char_reg;
    assign out_ch.last_of_run = out_last_reg;

endmodule

[hw/rtl/lfte_checker.sv]
// ----------------------------------------------------------------------------
// lfte_checker
// Port-level checks for the line folder, bound to the top level.
// ----------------------------------------------------------------------------
module lfte_checker
    import lfte_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic [CHAR_W-1:0] char_in,
    input logic              out_valid,
    input logic              out_ready,
    input logic [CHAR_W-1:0] char_out,
    input logic              last_of_run
);

    // A stalled output item holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(char_out) && $stable(last_of_run))
        else $error("output item changed while stalled");

    // Every run of results ends with a newline.
    a_last_nl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_run |-> char_out == CH_NL)
        else $error("final result of an item is not a newline");

    // While a line is still being emitted no new item is taken.
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> !in_ready)
        else $error("input taken in the middle of a line");

    // Taking a tab makes the input busy.
    a_tab_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && char_in == CH_TAB |=> !in_ready)
        else $error("input taken right after a tab");

endmodule

bind line_folder_with_tab_expansion lfte_checker u_lfte_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .char_in     (in_ch.char_in),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .char_out    (out_ch.char_out),
    .last_of_run (out_ch.last_of_run)
);

[dv/tb_line_folder_with_tab_expansion.sv]
// ----------------------------------------------------------------------------
// tb_line_folder_with_tab_expansion
// Self-checking testbench for the line folder with tab expansion.
// A queue of characters feeds a clocked driver on the input channel. Every
// accepted item runs through a local model of the line store, which queues
// the characters and newlines that the block must emit. A clocked monitor
// on the output channel compares each emitted item with the oldest queued
// one. The run goes through several tab step settings, with random idling
// on both channels, one long output stall and a calm final phase.
// ----------------------------------------------------------------------------
module tb_line_folder_with_tab_expansion;

    import lfte_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LW          = LINE_WIDTH_DEF;
    localparam int CLK_HALF    = 5;
    localparam int RESET_TICKS = 4;
    localparam int SETTLE      = 150;
    localparam int HOLD_CYCLES = 400;
    localparam int LIMIT       = 400000;
    localparam int SHOW_MAX    = 10;

    // One emitted character and its end-of-run flag.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } out_item_t;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [STEP_W-1:0] cfg_wr_data = '0;
    logic              send_valid  = 1'b0;
    logic [CHAR_W-1:0] send_char   = '0;
    logic              recv_ready  = 1'b0;

    // Characters still to be offered and characters still to be emitted.
    logic [CHAR_W-1:0] tx_chars[$];
    out_item_t         expected_out[$];

    // Local copy of the line store, its fill level and the tab step.
    logic [CHAR_W-1:0] line_buf[LW];
    int                line_len      = 0;
    logic [STEP_W-1:0] tab_step_seen = TAB_STEP_RST;

    int idle_pct    = 0;
    int send_gap    = 0;
    int recv_gap    = 0;
    int fail_count  = 0;
    int cycle_count = 0;
    int hold_left   = 0;
    bit hold_go     = 1'b0;
    bit hold_taken  = 1'b0;

    lfte_in_if  in_ch();
    lfte_out_if out_ch();

    assign in_ch.valid   = send_valid;
    assign in_ch.char_in = send_char;
    assign out_ch.ready  = recv_ready;

    line_folder_with_tab_expansion #(
        .LINE_WIDTH(LW)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    always #(CLK_HALF) clk = ~clk;

    // Queue the first n stored characters and a newline, unless n is zero.
    function automatic void queue_line(input int n);
        out_item_t item;
        for (int i = 0; i < n; i++)
        begin
            item.ch   = line_buf[i];
            item.last = 1'b0;
            expected_out.push_back(item);
        end
        if (n > 0)
        begin
            item.ch   = CH_NL;
            item.last = 1'b0;
            expected_out.push_back(item);
        end
    endfunction

    // Advance the line store by one accepted character and queue its output.
    function automatic void fold_char(input logic [CHAR_W-1:0] ch);
        int        pos;
        int        step;
        int        i;
        int        brk;
        int        before_n;
        out_item_t tail;
        before_n = expected_out.size();
        pos      = (line_len >= LW) ? 0 : line_len;
        step     = (tab_step_seen == '0) ? 1 : int'(tab_step_seen);
        if (ch == CH_TAB)
        begin
            // Pad with blanks up to the next tab stop.
            line_buf[pos] = CH_SPACE;
            pos++;
            while (pos < LW && (pos % step) != 0)
            begin
                line_buf[pos] = CH_SPACE;
                pos++;
            end
            if (pos < LW)
                line_len = pos;
            else
            begin
                queue_line(pos);
                line_len = 0;
            end
        end
        else if (ch == CH_NL)
        begin
            queue_line(pos);
            line_len = 0;
        end
        else
        begin
            line_buf[pos] = ch;
            pos++;
            if (pos >= LW)
            begin
                // Fold after the last blank past the first column, or at full width.
                i = pos - 1;
                while (i > 0 && line_buf[i] != CH_SPACE)
                    i--;
                brk = (i == 0) ? LW : i + 1;
                queue_line(brk);
                if (brk >= LW)
                    line_len = 0;
                else
                begin
                    for (int k = 0; k < LW - brk; k++)
                        line_buf[k] = line_buf[k + brk];
                    line_len = LW - brk;
                end
            end
            else
                line_len = pos;
        end
        // Flag the final character caused by this item.
        if (expected_out.size() > before_n)
        begin
            tail      = expected_out.pop_back();
            tail.last = 1'b1;
            expected_out.push_back(tail);
        end
    endfunction

    // Input driver: offers queued characters, with random idle bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_valid <= 1'b0;
            send_char  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (send_valid && in_ch.ready)
            begin
                fold_char(send_char);
                tx_chars.delete(0);
            end
            if (!send_valid || in_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    send_valid <= 1'b0;
                end
                else if (idle_pct > 0 && $urandom_range(99) < idle_pct)
                begin
                    send_gap = $urandom_range(0, 3);
                    send_valid <= 1'b0;
                end
                else if (tx_chars.size() > 0)
                begin
                    send_valid <= 1'b1;
                    send_char  <= tx_chars[0];
                end
                else
                    send_valid <= 1'b0;
            end
        end
    end

    // Long output stall, started once on request and counted down here.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end
        else if (hold_go && !hold_taken)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Output monitor: checks each emitted item and drives ready.
    always @(posedge clk or negedge rst_n)
    begin : out_monitor
        out_item_t want;
        if (!rst_n)
        begin
            recv_ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (out_ch.valid && recv_ready)
            begin
                if (expected_out.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= SHOW_MAX)
                        $display("unexpected item: char %0d last %0b",
                                 out_ch.char_out, out_ch.last_of_run);
                end
                else
                begin
                    want = expected_out.pop_front();
                    if (out_ch.char_out !== want.ch || out_ch.last_of_run !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= SHOW_MAX)
                            $display("mismatch: char %0d last %0b, wanted char %0d last %0b",
                                     out_ch.char_out, out_ch.last_of_run, want.ch, want.last);
                    end
                end
            end
            if (hold_left > 0)
                recv_ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                recv_gap--;
                recv_ready <= 1'b0;
            end
            else if (idle_pct > 0 && $urandom_range(99) < idle_pct)
            begin
                recv_gap = $urandom_range(0, 3);
                recv_ready <= 1'b0;
            end
            else
                recv_ready <= 1'b1;
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Wait until every item is taken and emitted, then let the block settle.
    task automatic drain();
        while (tx_chars.size() != 0 || send_valid)
            @(posedge clk);
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write the tab step register while the block is idle.
    task automatic set_tab_step(input logic [STEP_W-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        tab_step_seen = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Queue about n characters of text: mostly words and blanks, with tabs,
    // newlines, blank runs, words about as long as a line or longer, and random bytes.
    task automatic queue_text(input int n);
        int count;
        int pick;
        int len;
        count = 0;
        while (count < n)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                len = $urandom_range(1, 10);
                repeat (len) tx_chars.push_back(CHAR_W'($urandom_range(33, 126)));
                tx_chars.push_back(CH_SPACE);
                count += len + 1;
            end
            else if (pick < 65)
            begin
                tx_chars.push_back(CH_TAB);
                count++;
            end
            else if (pick < 73)
            begin
                len = $urandom_range(1, 2);
                repeat (len) tx_chars.push_back(CH_NL);
                count += len;
            end
            else if (pick < 78)
            begin
                len = $urandom_range(LW - 1, LW + 8);
                repeat (len) tx_chars.push_back(CHAR_W'($urandom_range(33, 255)));
                count += len;
            end
            else if (pick < 90)
            begin
                tx_chars.push_back(CHAR_W'($urandom_range(255)));
                count++;
            end
            else
            begin
                len = $urandom_range(1, 3);
                repeat (len) tx_chars.push_back(CH_SPACE);
                count += len;
            end
        end
    endtask

    // Test sequence.
    initial
    begin
        repeat (RESET_TICKS) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed items at the reset tab step: an empty line, byte extremes,
        // a tab run that reaches the line end, and a mid-column tab.
        idle_pct = 20;
        tx_chars.push_back(CH_NL);
        tx_chars.push_back(8'h00);
        tx_chars.push_back(8'hFF);
        tx_chars.push_back(CH_SPACE);
        tx_chars.push_back(8'h41);
        tx_chars.push_back(CH_NL);
        repeat (4) tx_chars.push_back(CH_TAB);
        tx_chars.push_back(CH_NL);
        tx_chars.push_back(8'h61);
        tx_chars.push_back(8'h62);
        tx_chars.push_back(CH_TAB);
        tx_chars.push_back(8'h63);
        tx_chars.push_back(CH_NL);
        tx_chars.push_back(CH_SPACE);
        tx_chars.push_back(CH_NL);
        drain();

        // Widest tab step: every tab runs to the end of the line.
        set_tab_step(6'd63);
        @(negedge clk);
        idle_pct = 30;
        queue_text(55);
        drain();

        // Unit tab step, with a long output stall while input keeps coming.
        set_tab_step(6'd1);
        @(negedge clk);
        idle_pct = 10;
        queue_text(55);
        hold_go = 1'b1;
        drain();

        // Zero tab step acts as one: a tab is a single blank.
        set_tab_step(6'd0);
        @(negedge clk);
        idle_pct = 25;
        tx_chars.push_back(CH_TAB);
        tx_chars.push_back(8'h7A);
        tx_chars.push_back(CH_TAB);
        tx_chars.push_back(CH_NL);
        queue_text(50);
        drain();

        // Random tab step.
        set_tab_step(STEP_W'($urandom_range(2, 62)));
        @(negedge clk);
        idle_pct = 15;
        queue_text(60);
        drain();

        // Final phase at full rate on both sides.
        set_tab_step(6'd3);
        @(negedge clk);
        idle_pct = 0;
        queue_text(70);
        drain();

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/lfte_pkg.sv
hw/rtl/lfte_if.sv
hw/rtl/lfte_cell.sv
hw/rtl/line_folder_with_tab_expansion.sv
hw/rtl/lfte_checker.sv
dv/tb_line_folder_with_tab_expansion.sv
